@@ src/fpod_pkg.sv @@
// Shared constants for the flux peak onset detector.
`default_nettype none
package fpod_pkg;
  localparam int MAG_W = 16;
  localparam int FLUX_W = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_OFFSET = 1'b1;

  localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 16'd256;
  localparam logic [CFG_DATA_W-1:0] OFFSET_RESET = 16'd5;
  localparam logic [MAG_W-1:0] SPREAD_MAX = 16'hFFFF;
endpackage
`default_nettype wire

@@ src/fpod_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module fpod_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/flux_peak_onset_detector.sv @@
// Flux peak onset detector: top level with history RAM and sequencer.
//
// Input channel (in_valid/in_ready, magnitude) takes one sample per
// transaction; output channel (out_valid/out_ready) returns one result
// (fired, peak_seen, spread) per sample, in order. Configuration is a plain
// write port (cfg_we, cfg_index, cfg_data); the user must write it only
// while the block is idle, which the block itself does not enforce.
// Magnitude and flux history share one RAM. A sample without a flux peak
// goes straight to the output; with a peak the sequencer walks the onset,
// the valley and the window, then runs the bit-serial multiply, divide
// and square root (NW = 32 + 2*CW, CW = clog2(HISTORY_DEPTH+1)).
// One sample is processed at a time; in_ready is high when idle and no result waits.
// The result sits in an output register, so the next sample is accepted
// while it waits; a stalled receiver holds the following result back.
// Reset clears the history fill, the firing mark, out_valid and
// restores the default threshold gain and offset; no RAM clearing pass.
`default_nettype none
module flux_peak_onset_detector
  import fpod_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [MAG_W-1:0]      magnitude,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       fired,
  output logic                       peak_seen,
  output logic [MAG_W-1:0]           spread,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = MAG_W + CW;
  localparam int QW = 2 * MAG_W + CW;
  localparam int NW = QW + CW;
  localparam int DW = 2 * CW;
  localparam int HW = (NW + 1) / 2;
  localparam int RW = 2 * HW;
  localparam int STW = $clog2(NW + 1);
  localparam int TW = 2 * MAG_W + 1;
  localparam int RHW = TW + CW + 1;
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(HISTORY_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_ONS_RD  = 13'b0000000000010,
    S_ONS_CHK = 13'b0000000000100,
    S_VAL_RD  = 13'b0000000001000,
    S_VAL_CHK = 13'b0000000010000,
    S_WIN     = 13'b0000000100000,
    S_SUM_RD  = 13'b0000001000000,
    S_SUM_ACC = 13'b0000010000000,
    S_NMUL    = 13'b0000100000000,
    S_DIV     = 13'b0001000000000,
    S_SQRT    = 13'b0010000000000,
    S_FIRE1   = 13'b0100000000000,
    S_FIRE2   = 13'b1000000000000
  } state_t;

  state_t state;
  logic done;

  logic [CW-1:0] fill;
  logic [AW-1:0] newest;
  logic [AW-1:0] mark_slot;
  logic mark_valid;
  logic [MAG_W-1:0] gain;
  logic [MAG_W-1:0] offset;
  logic [MAG_W-1:0] last_mag;
  logic signed [FLUX_W-1:0] last_flux;

  logic [CW-1:0] age;
  logic [CW-1:0] onset;
  logic [CW-1:0] valley;
  logic [CW-1:0] n;
  logic [SW-1:0] sum;
  logic [QW-1:0] sq;
  logic [NW-1:0] ssq;
  logic [DW-1:0] den;
  logic [NW-1:0] acc;
  logic [NW-1:0] mq;
  logic [CW-1:0] mn;
  logic [NW-1:0] dnum;
  logic [DW-1:0] rem;
  logic [RW-1:0] sv;
  logic [RW-1:0] sres;
  logic [RW-1:0] sbit;
  logic [STW-1:0] step;
  logic [MAG_W-1:0] sd;
  logic [TW-1:0] tprod;
  logic [CW+MAG_W-1:0] nm;
  logic res_fire;
  logic res_peak;
  logic [MAG_W-1:0] res_spread;

  logic accept;
  logic [AW-1:0] next_slot;
  logic signed [FLUX_W-1:0] flux_new;
  logic [FLUX_W:0] flux_diff;
  logic [CW-1:0] fill_next;
  logic peak;
  logic [CW-1:0] rd_age;
  logic [CW:0] slot_sum;
  logic [AW-1:0] rd_slot;
  logic [CW:0] mark_sum;
  logic [CW-1:0] mark_dist;
  logic [FLUX_W+MAG_W-1:0] rdata;
  logic signed [FLUX_W-1:0] rd_flux;
  logic [MAG_W-1:0] rd_mag;
  logic [CW-1:0] win_n;
  logic [DW:0] trial;
  logic [RW:0] sq_one;
  logic [HW-1:0] sd_full;
  logic [RHW-1:0] rhs;
  logic [RHW-1:0] lhs;

  assign in_ready = (state == S_IDLE) && !done;
  assign accept = in_valid && in_ready;
  assign next_slot = (newest == LAST_SLOT) ? '0 : newest + 1'b1;
  assign flux_new = (fill == '0) ? '0
                    : $signed({1'b0, magnitude}) - $signed({1'b0, last_mag});
  assign flux_diff = {flux_new[FLUX_W-1], flux_new} - {last_flux[FLUX_W-1], last_flux};
  assign fill_next = (fill < DEPTH_C) ? fill + 1'b1 : fill;
  assign peak = (fill_next >= CW'(2)) && (flux_new[FLUX_W-1] || flux_new == '0)
                && !last_flux[FLUX_W-1] && (last_flux != '0) && flux_diff[FLUX_W];

  assign rd_age = (state == S_VAL_RD) ? valley : age;
  assign slot_sum = (CW + 1)'(newest) + DEPTH_W - (CW + 1)'(rd_age);
  assign rd_slot = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : AW'(slot_sum);
  assign mark_sum = (CW + 1)'(newest) + DEPTH_W - (CW + 1)'(mark_slot);
  assign mark_dist = (mark_sum >= DEPTH_W) ? CW'(mark_sum - DEPTH_W) : CW'(mark_sum);

  assign rd_flux = rdata[FLUX_W+MAG_W-1:MAG_W];
  assign rd_mag = rdata[MAG_W-1:0];
  assign win_n = (valley > onset) ? valley - onset : '0;
  assign trial = {rem, dnum[NW-1]};
  assign sq_one = {1'b0, sres} + {1'b0, sbit};
  assign sd_full = sres[HW-1:0];
  assign rhs = RHW'({sum, 8'd0}) + RHW'(n) * RHW'(tprod);
  assign lhs = RHW'({nm, 8'd0});

  fpod_ram #(
    .WIDTH(FLUX_W + MAG_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk(clk),
    .we(accept),
    .waddr(next_slot),
    .wdata({flux_new, magnitude}),
    .raddr(rd_slot),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      fill <= '0;
      newest <= '0;
      mark_slot <= '0;
      mark_valid <= 1'b0;
      gain <= GAIN_RESET;
      offset <= OFFSET_RESET;
      last_flux <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD_GAIN: gain <= cfg_data;
          REG_FIRE_OFFSET: offset <= cfg_data;
          default: ;
        endcase
      end
      if (done && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        fired <= res_fire;
        peak_seen <= res_peak;
        spread <= res_spread;
        done <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (fill == DEPTH_C && mark_valid && mark_slot == next_slot) begin
              mark_valid <= 1'b0;
            end
            newest <= next_slot;
            fill <= fill_next;
            last_mag <= magnitude;
            last_flux <= flux_new;
            res_peak <= peak;
            res_fire <= 1'b0;
            res_spread <= '0;
            age <= CW'(2);
            if (peak) begin
              state <= S_ONS_RD;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_ONS_RD: begin
          if (age < fill) begin
            state <= S_ONS_CHK;
          end else begin
            onset <= age - 1'b1;
            valley <= mark_valid ? mark_dist : fill;
            state <= mark_valid ? S_VAL_RD : S_WIN;
          end
        end
        S_ONS_CHK: begin
          if (!rd_flux[FLUX_W-1] && rd_flux != '0) begin
            age <= age + 1'b1;
            state <= S_ONS_RD;
          end else begin
            onset <= age - 1'b1;
            valley <= mark_valid ? mark_dist : fill;
            state <= mark_valid ? S_VAL_RD : S_WIN;
          end
        end
        S_VAL_RD: begin
          state <= (valley != '0) ? S_VAL_CHK : S_WIN;
        end
        S_VAL_CHK: begin
          if (rd_flux[FLUX_W-1]) begin
            valley <= valley - 1'b1;
            state <= S_VAL_RD;
          end else begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          n <= win_n;
          age <= onset;
          sum <= '0;
          sq <= '0;
          if (win_n < CW'(2)) begin
            state <= S_IDLE;
            done <= 1'b1;
          end else begin
            state <= S_SUM_RD;
          end
        end
        S_SUM_RD: begin
          if (age < valley) begin
            state <= S_SUM_ACC;
          end else begin
            ssq <= NW'(sum) * NW'(sum);
            den <= DW'(n) * DW'(n - 1'b1);
            acc <= '0;
            mq <= NW'(sq);
            mn <= n;
            step <= '0;
            state <= S_NMUL;
          end
        end
        S_SUM_ACC: begin
          sum <= sum + SW'(rd_mag);
          sq <= sq + QW'(rd_mag) * QW'(rd_mag);
          age <= age + 1'b1;
          state <= S_SUM_RD;
        end
        S_NMUL: begin
          if (step == STW'(CW)) begin
            dnum <= acc - ssq;
            rem <= '0;
            step <= '0;
            state <= S_DIV;
          end else begin
            if (mn[0]) begin
              acc <= acc + mq;
            end
            mq <= mq << 1;
            mn <= mn >> 1;
            step <= step + 1'b1;
          end
        end
        S_DIV: begin
          if (step == STW'(NW)) begin
            sv <= RW'(dnum);
            sres <= '0;
            sbit <= RW'(1) << (RW - 2);
            step <= '0;
            state <= S_SQRT;
          end else begin
            if (trial >= {1'b0, den}) begin
              rem <= DW'(trial - {1'b0, den});
              dnum <= {dnum[NW-2:0], 1'b1};
            end else begin
              rem <= trial[DW-1:0];
              dnum <= {dnum[NW-2:0], 1'b0};
            end
            step <= step + 1'b1;
          end
        end
        S_SQRT: begin
          if (step == STW'(HW)) begin
            sd <= (sd_full > HW'(SPREAD_MAX)) ? SPREAD_MAX : sd_full[MAG_W-1:0];
            res_spread <= (sd_full > HW'(SPREAD_MAX)) ? SPREAD_MAX : sd_full[MAG_W-1:0];
            state <= S_FIRE1;
          end else begin
            if ({1'b0, sv} >= sq_one) begin
              sv <= RW'({1'b0, sv} - sq_one);
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
            step <= step + 1'b1;
          end
        end
        S_FIRE1: begin
          tprod <= TW'(sd) * TW'(gain) + TW'({offset, 8'd0});
          nm <= (CW + MAG_W)'(n) * (CW + MAG_W)'(last_mag);
          state <= S_FIRE2;
        end
        S_FIRE2: begin
          if (lhs > rhs) begin
            res_fire <= 1'b1;
            mark_slot <= newest;
            mark_valid <= 1'b1;
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_fire_needs_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> peak_seen)
    else $error("firing without a flux peak");

  a_mark_on_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(mark_valid) |-> res_fire && done)
    else $error("firing mark set without a firing");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_C)
    else $error("history fill beyond depth");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(spread))
    else $error("pending result lost");
endmodule
`default_nettype wire

@@ bench/tb_flux_peak_onset_detector.sv @@
// Self-checking testbench for the flux peak onset detector.
`timescale 1ns / 1ps
`default_nettype none
class onset_scoreboard;
  typedef struct packed {
    logic       fired;
    logic       peak;
    logic [15:0] spread;
  } onset_result_t;

  localparam int DEPTH = 64;
  logic [15:0] mag_hist [DEPTH];
  int          flux_hist [DEPTH];
  int unsigned fill;
  int unsigned newest;
  int unsigned mark_slot;
  bit          mark_valid;
  int unsigned gain;
  int unsigned offset;
  onset_result_t pending [$];
  int errors;
  int fires;
  int peaks;
  int checked;

  function new();
    fill = 0; newest = 0; mark_slot = 0; mark_valid = 0;
    gain = 256; offset = 5; errors = 0; fires = 0; peaks = 0; checked = 0;
  endfunction

  function void set_reg(bit idx, logic [15:0] val);
    if (idx == fpod_pkg::REG_THRESHOLD_GAIN) gain = val;
    else offset = val;
  endfunction

  function int unsigned slot_of(int unsigned age);
    return (newest + DEPTH - (age % DEPTH)) % DEPTH;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function void note_sample(logic [15:0] mag);
    int unsigned nxt, s, onset, valley, n, k;
    int f0, f1, fx;
    bit pk, fr;
    longint unsigned sum, sq, x, vr, sd, lhs, rhs;
    onset_result_t res;
    nxt = (newest + 1) % DEPTH;
    fx = 0; pk = 0; fr = 0;
    res.spread = 0;
    if (fill >= DEPTH && mark_valid && mark_slot == nxt) mark_valid = 0;
    if (fill > 0) fx = int'(mag) - int'(mag_hist[newest]);
    mag_hist[nxt] = mag;
    flux_hist[nxt] = fx;
    newest = nxt;
    if (fill < DEPTH) fill++;
    if (fill >= 2) begin
      f0 = flux_hist[slot_of(0)];
      f1 = flux_hist[slot_of(1)];
      pk = (f0 <= 0) && (f1 > 0) && (f0 - f1 < 0);
    end
    if (pk) begin
      s = 1;
      while (s < fill && flux_hist[slot_of(s)] > 0) s++;
      onset = s - 1;
      if (!mark_valid) begin
        valley = fill;
      end else begin
        valley = (newest + DEPTH - mark_slot) % DEPTH;
        while (valley > 0 && flux_hist[slot_of(valley)] < 0) valley--;
      end
      n = valley > onset ? valley - onset : 0;
      if (n >= 2) begin
        sum = 0; sq = 0;
        for (k = onset; k < valley; k++) begin
          x = mag_hist[slot_of(k)];
          sum += x;
          sq += x * x;
        end
        vr = (n * sq - sum * sum) / (n * (n - 1));
        sd = int_sqrt(vr);
        res.spread = sd > 65535 ? 16'hFFFF : sd[15:0];
        lhs = 256 * longint'(n) * mag;
        rhs = 256 * sum + n * (sd * gain + 256 * longint'(offset));
        if (lhs > rhs) begin
          fr = 1;
          mark_slot = newest;
          mark_valid = 1;
        end
      end
    end
    res.fired = fr;
    res.peak = pk;
    pending.push_back(res);
    if (pk) peaks++;
    if (fr) fires++;
  endfunction

  function void check_result(logic f, logic p, logic [15:0] sp);
    onset_result_t e;
    checked++;
    if (pending.size() == 0) begin
      $error("result with no transaction outstanding");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (f !== e.fired) begin
      $error("fired: expected %0d, got %0d", e.fired, f);
      errors++;
    end
    if (p !== e.peak) begin
      $error("peak_seen: expected %0d, got %0d", e.peak, p);
      errors++;
    end
    if (sp !== e.spread) begin
      $error("spread: expected %0d, got %0d", e.spread, sp);
      errors++;
    end
  endfunction
endclass

module tb_flux_peak_onset_detector;
  import fpod_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [MAG_W-1:0] magnitude = '0;
  logic out_valid;
  logic out_ready = 0;
  logic fired;
  logic peak_seen;
  logic [MAG_W-1:0] spread;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  onset_scoreboard board = new();
  bit quiet = 0;
  int cycles = 0;
  int sent = 0;

  always #2 clk = ~clk;

  flux_peak_onset_detector DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && out_valid && out_ready) board.check_result(fired, peak_seen, spread);
  end

  always @(negedge clk)
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);

  // in_valid stays high after a transaction until the next sample or a drain
  task automatic send_sample(logic [15:0] m);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < 12) @(negedge clk);
    end
    in_valid <= 1;
    magnitude <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(m);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    board.set_reg(idx, val);
  endtask

  // rising run, then a fall, with random content: most often a flux peak
  task automatic send_burst(int base, int rise_len, int step);
    int v;
    v = base;
    for (int i = 0; i < rise_len; i++) begin
      v = v + $urandom_range(step) + 1;
      if (v > 65535) v = 65535;
      send_sample(v[15:0]);
    end
    for (int i = 0; i < $urandom_range(6, 1); i++) begin
      v = v - $urandom_range(step) - 1;
      if (v < 0) v = 0;
      send_sample(v[15:0]);
    end
  endtask

  initial begin
    logic [15:0] gains [5];
    logic [15:0] offs [5];
    gains = '{16'd256, 16'd0, 16'hFFFF, 16'd64, 16'd512};
    offs = '{16'd5, 16'd0, 16'hFFFF, 16'd200, 16'd1};
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes, single sample, plateau, big peak
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    send_sample(16'd0);
    send_sample(16'd100);
    send_sample(16'd100);
    send_sample(16'd50);
    for (int i = 0; i < 6; i++) send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0000);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_THRESHOLD_GAIN, gains[ph]);
      write_reg(REG_FIRE_OFFSET, offs[ph]);
      cfg_we <= 0;
      quiet = (ph == 2);
      while (sent < 20 + (ph + 1) * 230) begin
        if ($urandom_range(9) < 8)
          send_burst($urandom_range(65535 >> $urandom_range(8)), $urandom_range(8, 1),
                     1 << $urandom_range(12));
        else
          send_sample(16'($urandom));
        if ($urandom_range(99) == 0) drain();
      end
      drain();
    end
    quiet = 0;

    $display("Sent %0d samples, checked %0d results: %0d flux peaks, %0d firings.",
             sent, board.checked, board.peaks, board.fires);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
